// ----- hw/rtl/mass_pkg.sv -----
`default_nettype none

package mass_pkg;

  // Default sweep size
  localparam int NUM_CHIPS_DEF    = 4;
  localparam int NUM_CHANNELS_DEF = 8;

  // Fixed field widths
  localparam int CHIP_W   = 2;
  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 12;

  // Item kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // First command byte: start bit and single-ended bit
  localparam logic [7:0] CMD_START_SGL = 8'h06;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_mid_byte;
    logic [7:0] rx_last_byte;
    logic [3:0] query_chip;
    logic [3:0] query_channel;
  } in_item_t;

  typedef struct packed {
    logic                select_active;
    logic [CHIP_W-1:0]   select_chip;
    logic                start_transfer;
    logic [7:0]          cmd_byte0;
    logic [7:0]          cmd_byte1;
    logic [7:0]          cmd_byte2;
    logic [SAMPLE_W-1:0] read_value;
    logic                sweep_done;
  } out_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mass_seq.sv -----
`default_nettype none

module mass_seq #(
  parameter int NUM_CHIPS    = mass_pkg::NUM_CHIPS_DEF,
  parameter int NUM_CHANNELS = mass_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mass_pkg::in_item_t in_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data,
  input  wire logic              room,
  output logic                   push,
  output mass_pkg::out_res_t     res
);

  localparam int DEPTH = NUM_CHIPS * NUM_CHANNELS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SELECT,
    PH_WAIT
  } phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [mass_pkg::CHIP_W-1:0]       chip_r, chip_nxt;
  logic [mass_pkg::CHAN_W-1:0]       chan_r, chan_nxt;
  logic                              scan_enable_r;
  logic [mass_pkg::SAMPLE_W-1:0]     table_r [DEPTH];
  logic                              in_valid_r;
  mass_pkg::in_item_t                in_r;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_idx;
  logic [IDX_W-1:0]                  rd_idx;
  logic                              rd_in_range;
  logic [mass_pkg::SAMPLE_W-1:0]     rx_sample;
  logic                              last_chan;
  logic                              last_chip;

  // Input stage handshake: hold the item until the result buffer has room
  assign push      = in_valid_r && room;
  assign in_stall  = in_valid_r && !room;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (push) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Table addressing
  assign wr_idx = IDX_W'(6'(chip_r) * 6'(NUM_CHANNELS) + 6'(chan_r));
  assign rd_idx = IDX_W'(8'(in_r.query_chip) * 8'(NUM_CHANNELS) + 8'(in_r.query_channel));
  assign rd_in_range = (in_r.query_chip < 4'(NUM_CHIPS)) &&
                       (in_r.query_channel < 4'(NUM_CHANNELS));
  assign rx_sample = {in_r.rx_mid_byte[3:0], in_r.rx_last_byte};
  assign last_chan = (chan_r == mass_pkg::CHAN_W'(NUM_CHANNELS - 1));
  assign last_chip = (chip_r == mass_pkg::CHIP_W'(NUM_CHIPS - 1));

  // Next state and result for the item in the input stage
  always_comb begin
    phase_nxt          = phase_r;
    chip_nxt           = chip_r;
    chan_nxt           = chan_r;
    wr_en              = 1'b0;
    res                = '0;
    case (in_r.kind)
      mass_pkg::KIND_TICK: begin
        case (phase_r)
          PH_IDLE: begin
            if (scan_enable_r) begin
              phase_nxt = PH_SELECT;
            end
          end
          PH_SELECT: begin
            res.start_transfer = 1'b1;
            res.cmd_byte0      = mass_pkg::CMD_START_SGL | {7'd0, chan_r[2]};
            res.cmd_byte1      = {chan_r[1:0], 6'd0};
            phase_nxt          = PH_WAIT;
          end
          default: begin
          end
        endcase
      end
      mass_pkg::KIND_DONE: begin
        if (phase_r == PH_WAIT) begin
          wr_en = 1'b1;
          if (last_chan) begin
            chan_nxt  = '0;
            phase_nxt = PH_IDLE;
            if (last_chip) begin
              chip_nxt       = '0;
              res.sweep_done = 1'b1;
            end else begin
              chip_nxt = chip_r + 1'b1;
            end
          end else begin
            chan_nxt  = chan_r + 1'b1;
            phase_nxt = PH_SELECT;
          end
        end
      end
      mass_pkg::KIND_READ: begin
        if (rd_in_range) begin
          res.read_value = table_r[rd_idx];
        end
      end
      default: begin
      end
    endcase
    res.select_active = (phase_nxt == PH_WAIT);
    res.select_chip   = chip_nxt;
  end

  // Sequencer state, enable register and sample table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      chip_r        <= '0;
      chan_r        <= '0;
      scan_enable_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        table_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        scan_enable_r <= cfg_data;
      end
      if (push) begin
        phase_r <= phase_nxt;
        chip_r  <= chip_nxt;
        chan_r  <= chan_nxt;
        if (wr_en) begin
          table_r[wr_idx] <= rx_sample;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A command goes out only from select, and the sequencer then waits
  a_start_from_select: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.start_transfer |-> phase_r == PH_SELECT)
    else $error("command issued outside select");

  a_start_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.start_transfer |=> phase_r == PH_WAIT)
    else $error("no wait after command");

  // Sweep end only on the last channel of the last chip
  a_sweep_done: assert property (@(posedge clk) disable iff (!rst_n)
    push && res.sweep_done |-> phase_r == PH_WAIT && last_chan && last_chip)
    else $error("sweep_done out of place");

  // Input stage never drops an item
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !room |=> in_valid_r && $stable(in_r))
    else $error("pending item lost");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/mass_obuf.sv -----
`default_nettype none

module mass_obuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire mass_pkg::out_res_t res,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mass_pkg::out_res_t      out_data
);

  logic [1:0]         cnt_r, cnt_nxt;
  mass_pkg::out_res_t head_r;
  mass_pkg::out_res_t skid_r;
  logic               pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign room      = (cnt_r != 2'd2);
  assign pop       = out_valid && !out_stall;

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Head and skid entries
  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      head_r <= skid_r;
    end
    if (push) begin
      if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
        head_r <= res;
      end else if (cnt_r == 2'd1) begin
        skid_r <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("result buffer overflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count corrupt");

  a_stalled_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(head_r))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/multi_adc_spi_scan_sequencer.sv -----
// Round-robin scan sequencer for a group of 8-channel 12-bit SPI converters.
// Input channel (in_valid / in_stall / in_data): poll ticks, transfer
// completions carrying the received bytes, and sample reads. Each transaction
// yields exactly one result transaction on out_valid / out_stall / out_data:
// chip select state, command bytes to shift out, read data and sweep_done.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes scan_enable; it is
// always ready and should be written only while the sequencer is quiet.
// An accepted item is registered in the input register and its result is
// then registered in the result buffer, which drives out_valid. One item
// per cycle is taken while the buffer has room, set by the combinational
// next-state logic between the input register and the two-entry buffer.
// When the receiver stalls, the result buffer fills (two entries) and the
// input register holds one more item; in_stall then rises until a result
// is taken. Synchronous reset puts the sequencer in idle at chip 0,
// channel 0, clears scan_enable and the sample table, and empties both
// stages; no clearing pass is needed.
`default_nettype none

module multi_adc_spi_scan_sequencer #(
  parameter int NUM_CHIPS    = mass_pkg::NUM_CHIPS_DEF,
  parameter int NUM_CHANNELS = mass_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mass_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mass_pkg::out_res_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);

  logic               room;
  logic               push;
  mass_pkg::out_res_t res;

  // Sequencer with input register and sample table
  mass_seq #(
    .NUM_CHIPS    (NUM_CHIPS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .room      (room),
    .push      (push),
    .res       (res)
  );

  // Result register with skid entry
  mass_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
